@@ hw/rtl/lgp_pkg.sv @@
`default_nettype none

package lgp_pkg;

    // Fixed-point limits and constants
    localparam logic [63:0]        LIM         = 64'h3FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0]        LIM_Q       = 64'h0FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] LIM_S       = 64'sh3FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] NLIM_S      = -64'sh3FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] OUT_MAX     = 64'sh007F_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] OUT_MIN     = 64'shFF80_0000_0000_0000;
    localparam logic signed [63:0] ONE_Q32     = 64'sh0000_0001_0000_0000;
    localparam logic signed [63:0] NEG_ONE_Q32 = 64'shFFFF_FFFF_0000_0000;
    localparam logic [63:0]        HALF_Q30    = 64'h0000_0000_2000_0000;
    localparam logic signed [32:0] ONE_Q30     = 33'sh0_4000_0000;
    localparam logic signed [31:0] NEG_ONE_Q30 = 32'shC000_0000;
    localparam logic [6:0]         SMALL_STEPS = 7'd8;
    localparam logic [6:0]         POINT_STEPS = 7'd92;

    // Shared arithmetic unit operations
    typedef enum logic [2:0] {
        ALU_MZH,
        ALU_MZL,
        ALU_MULS,
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef struct packed {
        alu_op_t            op;
        logic signed [63:0] a;
        logic signed [63:0] b;
        logic signed [31:0] z;
        logic [6:0]         c;
    } alu_req_t;

    typedef struct packed {
        logic signed [63:0] y;
        logic               sat;
    } alu_rsp_t;

    // Divider
    typedef enum logic {
        DIV_SMALL,
        DIV_POINT
    } div_kind_t;

    typedef struct packed {
        logic               start;
        div_kind_t          kind;
        logic signed [63:0] num;
        logic [6:0]         den_small;
        logic signed [32:0] den_pt;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic signed [63:0] y;
        logic               sat;
    } div_rsp_t;

    // Sequencer states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_INIT,
        ST_LOOP,
        ST_A_MZH,
        ST_A_MZL,
        ST_A_MC,
        ST_A_MK,
        ST_A_SUB,
        ST_A_DIV,
        ST_A_WAIT,
        ST_D_MC,
        ST_D_MZH,
        ST_D_MZL,
        ST_D_MC2,
        ST_D_ADD,
        ST_D_MK,
        ST_D_SUB,
        ST_D_DIV,
        ST_D_WAIT,
        ST_FIN,
        ST_G_ADD,
        ST_P_DIV1,
        ST_P_WAIT1,
        ST_G_SUB,
        ST_P_DIV2,
        ST_P_WAIT2,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

@@ hw/rtl/lgp_alu.sv @@
`default_nettype none

module lgp_alu
    import lgp_pkg::*;
(
    input  var alu_req_t req,
    output alu_rsp_t     rsp
);

    logic [63:0] am;
    logic [31:0] zm;
    logic [63:0] prod_hi;
    logic [63:0] prod_lo;
    logic [70:0] prod_s;
    logic [63:0] tq;
    logic [63:0] mag;
    logic        neg;
    logic signed [63:0] sum;

    // Magnitudes, the multiplier product each operation uses, and the add/sub sum
    always_comb
    begin
        am      = req.a[63] ? 64'(-req.a) : 64'(req.a);
        zm      = req.z[31] ? 32'(-req.z) : 32'(req.z);
        prod_hi = am[63:32] * zm;
        prod_lo = am[31:0] * zm + HALF_Q30;
        prod_s  = am * req.c;
        tq      = $unsigned(req.b);
        sum     = (req.op == ALU_SUB) ? (req.a - req.b) : (req.a + req.b);
    end

    // Result select, with clamping to +-LIM for all operations but MZH
    always_comb
    begin
        mag     = '0;
        neg     = 1'b0;
        rsp.y   = '0;
        rsp.sat = 1'b0;
        case (req.op)
            ALU_MZH:
            begin
                rsp.y = $signed(prod_hi);
            end
            ALU_MZL:
            begin
                neg = req.a[63] ^ req.z[31];
                if (tq > LIM_Q)
                begin
                    mag     = LIM;
                    rsp.sat = 1'b1;
                end
                else
                begin
                    mag = {tq[61:0], 2'b00} + {30'd0, prod_lo[63:30]};
                    if (mag > LIM)
                    begin
                        mag     = LIM;
                        rsp.sat = 1'b1;
                    end
                end
                rsp.y = neg ? -$signed(mag) : $signed(mag);
            end
            ALU_MULS:
            begin
                neg = req.a[63];
                if (prod_s > {7'd0, LIM})
                begin
                    mag     = LIM;
                    rsp.sat = 1'b1;
                end
                else
                begin
                    mag = prod_s[63:0];
                end
                rsp.y = neg ? -$signed(mag) : $signed(mag);
            end
            ALU_ADD, ALU_SUB:
            begin
                if (sum > LIM_S)
                begin
                    rsp.y   = LIM_S;
                    rsp.sat = 1'b1;
                end
                else if (sum < NLIM_S)
                begin
                    rsp.y   = NLIM_S;
                    rsp.sat = 1'b1;
                end
                else
                begin
                    rsp.y = sum;
                end
            end
            default:
            begin
                rsp.y = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ hw/rtl/lgp_div.sv @@
`default_nettype none

module lgp_div
    import lgp_pkg::*;
(
    input  var logic     clk,
    input  var logic     rst_n,
    input  var div_req_t req,
    output div_rsp_t     rsp
);

    logic [6:0]  cnt_reg, cnt_next;
    logic        done_reg, done_next;
    div_kind_t   kind_reg, kind_next;
    logic [63:0] sh_reg, sh_next;
    logic [31:0] rem_reg, rem_next;
    logic [63:0] q_reg, q_next;
    logic        ovf_reg, ovf_next;
    logic        neg_reg, neg_next;
    logic [6:0]  ds_reg, ds_next;
    logic [31:0] dm_reg, dm_next;

    logic        busy;
    logic [63:0] num_mag;
    logic [32:0] den_abs;
    logic [6:0]  rs;
    logic [6:0]  rc;
    logic [7:0]  qb;
    logic [32:0] rc33;
    logic        ge;
    logic [32:0] remp;
    logic        rnd;
    logic [63:0] qr;
    logic [63:0] mag;

    assign busy = (cnt_reg != 7'd0);

    // Radix-256 step for small divisors: eight compare-subtracts on 7 bits
    always_comb
    begin
        rs = rem_reg[6:0];
        qb = '0;
        for (int j = 7; j >= 0; j--)
        begin
            rc = {rs[5:0], sh_reg[56 + j]};
            if (rc >= ds_reg)
            begin
                rs    = rc - ds_reg;
                qb[j] = 1'b1;
            end
            else
            begin
                rs = rc;
            end
        end
    end

    // One restoring step for the divide by 1+z
    always_comb
    begin
        rc33 = {rem_reg, sh_reg[61]};
        ge   = (rc33 >= {1'b0, dm_reg});
        remp = ge ? (rc33 - {1'b0, dm_reg}) : rc33;
    end

    // Next-state of the divider registers
    always_comb
    begin
        num_mag   = req.num[63] ? 64'(-req.num) : 64'(req.num);
        den_abs   = req.den_pt[32] ? 33'(-req.den_pt) : 33'(req.den_pt);
        cnt_next  = cnt_reg;
        kind_next = kind_reg;
        sh_next   = sh_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        ovf_next  = ovf_reg;
        neg_next  = neg_reg;
        ds_next   = ds_reg;
        dm_next   = dm_reg;
        done_next = busy && (cnt_reg == 7'd1);
        if (req.start)
        begin
            kind_next = req.kind;
            ds_next   = req.den_small;
            dm_next   = den_abs[31:0];
            rem_next  = '0;
            q_next    = '0;
            ovf_next  = 1'b0;
            if (req.kind == DIV_SMALL)
            begin
                neg_next = req.num[63];
                sh_next  = num_mag + {58'd0, req.den_small[6:1]};
                cnt_next = SMALL_STEPS;
            end
            else
            begin
                neg_next = req.num[63] ^ req.den_pt[32];
                sh_next  = num_mag;
                cnt_next = POINT_STEPS;
            end
        end
        else if (busy)
        begin
            cnt_next = cnt_reg - 7'd1;
            if (kind_reg == DIV_SMALL)
            begin
                sh_next  = {sh_reg[55:0], 8'd0};
                rem_next = {25'd0, rs};
                q_next   = {q_reg[55:0], qb};
            end
            else
            begin
                sh_next  = {sh_reg[62:0], 1'b0};
                rem_next = remp[31:0];
                q_next   = {q_reg[62:0], ge};
                ovf_next = ovf_reg | (q_reg[63:62] != 2'b00);
            end
        end
    end

    // Rounding and clamping of the point quotient, and sign of the final quotient
    always_comb
    begin
        rnd     = !ovf_reg && ({rem_reg, 1'b0} >= {1'b0, dm_reg});
        qr      = q_reg + {63'd0, rnd};
        rsp.sat = 1'b0;
        if (kind_reg == DIV_SMALL)
        begin
            mag = q_reg;
        end
        else if (ovf_reg || (qr > LIM))
        begin
            mag     = LIM;
            rsp.sat = 1'b1;
        end
        else
        begin
            mag = qr;
        end
        rsp.y    = neg_reg ? -$signed(mag) : $signed(mag);
        rsp.done = done_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        sh_reg   <= sh_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        ovf_reg  <= ovf_next;
        neg_reg  <= neg_next;
        ds_reg   <= ds_next;
        dm_reg   <= dm_next;
    end

endmodule

`default_nettype wire

@@ hw/rtl/legendre_glj_poly_eval_core.sv @@
// The recurrence runs up to degree n for op 0/1 and n+1 for op 2/3, followed by one
//   divide by 1+z for the GLJ value and two for the GLJ derivative.
// Throughput: one item at a time; the next transfer is taken once the result is queued.
//   The recurrence runs on one shared multiply/add unit and one iterative divider.
// Reset: rst_n clears the sequencer and output valid; datapath registers are not reset.
`default_nettype none

module legendre_glj_poly_eval_core
    import lgp_pkg::*;
#(
    parameter int MAX_DEGREE = 63
)
(
    input  var logic               clk,
    input  var logic               rst_n,
    input  var logic               in_valid,
    output logic                   in_stall,
    input  var logic [1:0]         op,
    input  var logic signed [31:0] point,
    input  var logic [5:0]         degree,
    output logic                   out_valid,
    input  var logic               out_stall,
    output logic signed [55:0]     value,
    output logic                   bad_degree,
    output logic                   saturated
);

    localparam logic [7:0] MAX_D8 = 8'(MAX_DEGREE);

    state_t state_reg, state_next;

    logic [1:0]         op_reg, op_next;
    logic signed [31:0] z_reg, z_next;
    logic [5:0]         n_reg, n_next;
    logic [6:0]         m_reg, m_next;
    logic [6:0]         k_reg, k_next;
    logic               sat_reg, sat_next;
    logic               bad_reg, bad_next;
    logic               near_reg, near_next;
    logic signed [63:0] a0_reg, a0_next;
    logic signed [63:0] a1_reg, a1_next;
    logic signed [63:0] d0_reg, d0_next;
    logic signed [63:0] d1_reg, d1_next;
    logic signed [63:0] pa_reg, pa_next;
    logic signed [63:0] pda_reg, pda_next;
    logic signed [63:0] an_reg, an_next;
    logic signed [63:0] r1_reg, r1_next;
    logic signed [63:0] r2_reg, r2_next;
    logic signed [63:0] tmp_reg, tmp_next;

    logic               out_valid_reg, out_valid_next;
    logic signed [55:0] value_reg, value_next;
    logic               bad_out_reg, bad_out_next;
    logic               sat_out_reg, sat_out_next;

    alu_req_t alu_req;
    alu_rsp_t alu_rsp;
    div_req_t div_req;
    div_rsp_t div_rsp;

    logic [5:0]         n_clamp;
    logic signed [32:0] onepz;
    logic               near_now;
    logic [6:0]         c_val;
    logic [6:0]         kp1;
    logic               out_free;
    logic               ov_hi;
    logic               ov_lo;
    logic signed [63:0] glj_end;

    lgp_alu u_alu
    (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    lgp_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Helpers
    always_comb
    begin
        n_clamp  = ({2'b00, degree} > MAX_D8) ? MAX_D8[5:0] : degree;
        onepz    = {z_reg[31], z_reg} + ONE_Q30;
        near_now = (onepz == -33'sd1) || (onepz == 33'sd0) || (onepz == 33'sd1);
        c_val    = {k_reg[5:0], 1'b1};
        kp1      = k_reg + 7'd1;
        out_free = !out_valid_reg || !out_stall;
        ov_hi    = (r1_reg > OUT_MAX);
        ov_lo    = (r1_reg < OUT_MIN);
        glj_end  = $signed({25'd0, ({1'b0, n_reg} + 7'd1), 32'd0});
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_INIT;
                end
            end
            ST_INIT:
            begin
                if (bad_reg || (op_reg == 2'd2 && near_now))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_LOOP;
                end
            end
            ST_LOOP:
            begin
                state_next = (k_reg == m_reg) ? ST_FIN : ST_A_MZH;
            end
            ST_A_MZH:   state_next = ST_A_MZL;
            ST_A_MZL:   state_next = ST_A_MC;
            ST_A_MC:    state_next = ST_A_MK;
            ST_A_MK:    state_next = ST_A_SUB;
            ST_A_SUB:   state_next = ST_A_DIV;
            ST_A_DIV:   state_next = ST_A_WAIT;
            ST_A_WAIT:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_D_MC;
                end
            end
            ST_D_MC:    state_next = ST_D_MZH;
            ST_D_MZH:   state_next = ST_D_MZL;
            ST_D_MZL:   state_next = ST_D_MC2;
            ST_D_MC2:   state_next = ST_D_ADD;
            ST_D_ADD:   state_next = ST_D_MK;
            ST_D_MK:    state_next = ST_D_SUB;
            ST_D_SUB:   state_next = ST_D_DIV;
            ST_D_DIV:   state_next = ST_D_WAIT;
            ST_D_WAIT:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_LOOP;
                end
            end
            ST_FIN:
            begin
                if (!op_reg[1] || near_reg)
                begin
                    state_next = ST_DONE;
                end
                else if (op_reg == 2'd2)
                begin
                    state_next = ST_P_DIV1;
                end
                else
                begin
                    state_next = ST_G_ADD;
                end
            end
            ST_G_ADD:   state_next = ST_P_DIV1;
            ST_P_DIV1:  state_next = ST_P_WAIT1;
            ST_P_WAIT1:
            begin
                if (div_rsp.done)
                begin
                    state_next = (op_reg == 2'd2) ? ST_DONE : ST_G_SUB;
                end
            end
            ST_G_SUB:   state_next = ST_P_DIV2;
            ST_P_DIV2:  state_next = ST_P_WAIT2;
            ST_P_WAIT2:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // Datapath, unit requests and output register
    always_comb
    begin
        op_next        = op_reg;
        z_next         = z_reg;
        n_next         = n_reg;
        m_next         = m_reg;
        k_next         = k_reg;
        sat_next       = sat_reg;
        bad_next       = bad_reg;
        near_next      = near_reg;
        a0_next        = a0_reg;
        a1_next        = a1_reg;
        d0_next        = d0_reg;
        d1_next        = d1_reg;
        pa_next        = pa_reg;
        pda_next       = pda_reg;
        an_next        = an_reg;
        r1_next        = r1_reg;
        r2_next        = r2_reg;
        tmp_next       = tmp_reg;
        value_next     = value_reg;
        bad_out_next   = bad_out_reg;
        sat_out_next   = sat_out_reg;
        out_valid_next = out_valid_reg && out_stall;

        alu_req.op     = ALU_ADD;
        alu_req.a      = '0;
        alu_req.b      = '0;
        alu_req.z      = z_reg;
        alu_req.c      = c_val;

        div_req.start     = 1'b0;
        div_req.kind      = DIV_SMALL;
        div_req.num       = r1_reg;
        div_req.den_small = kp1;
        div_req.den_pt    = onepz;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next  = op;
                    z_next   = point;
                    n_next   = n_clamp;
                    m_next   = op[1] ? ({1'b0, n_clamp} + 7'd1) : {1'b0, n_clamp};
                    k_next   = 7'd1;
                    sat_next = 1'b0;
                    bad_next = (degree == 6'd0);
                    a0_next  = ONE_Q32;
                    a1_next  = {{30{point[31]}}, point, 2'b00};
                    d0_next  = '0;
                    d1_next  = ONE_Q32;
                end
            end
            ST_INIT:
            begin
                near_next = near_now;
                if (bad_reg)
                begin
                    r1_next = '0;
                end
                else if (op_reg == 2'd2 && near_now)
                begin
                    r1_next = n_reg[0] ? -glj_end : glj_end;
                end
                else if (op_reg == 2'd3 && near_now)
                begin
                    // recurrence runs at z = -1
                    z_next  = NEG_ONE_Q30;
                    a1_next = NEG_ONE_Q32;
                end
            end
            ST_LOOP:
            begin
                if (k_reg == {1'b0, n_reg})
                begin
                    pa_next  = a1_reg;
                    pda_next = d1_reg;
                end
            end
            // P_{k+1} numerator
            ST_A_MZH:
            begin
                alu_req.op = ALU_MZH;
                alu_req.a  = a1_reg;
                tmp_next   = alu_rsp.y;
            end
            ST_A_MZL:
            begin
                alu_req.op = ALU_MZL;
                alu_req.a  = a1_reg;
                alu_req.b  = tmp_reg;
                r1_next    = alu_rsp.y;
                sat_next   = sat_reg | alu_rsp.sat;
            end
            ST_A_MC:
            begin
                alu_req.op = ALU_MULS;
                alu_req.a  = r1_reg;
                r1_next    = alu_rsp.y;
                sat_next   = sat_reg | alu_rsp.sat;
            end
            ST_A_MK:
            begin
                alu_req.op = ALU_MULS;
                alu_req.a  = a0_reg;
                alu_req.c  = k_reg;
                r2_next    = alu_rsp.y;
                sat_next   = sat_reg | alu_rsp.sat;
            end
            ST_A_SUB:
            begin
                alu_req.op = ALU_SUB;
                alu_req.a  = r1_reg;
                alu_req.b  = r2_reg;
                r1_next    = alu_rsp.y;
                sat_next   = sat_reg | alu_rsp.sat;
            end
            ST_A_DIV:
            begin
                div_req.start = 1'b1;
            end
            ST_A_WAIT:
            begin
                if (div_rsp.done)
                begin
                    an_next = div_rsp.y;
                end
            end
            // P'_{k+1} numerator
            ST_D_MC:
            begin
                alu_req.op = ALU_MULS;
                alu_req.a  = a1_reg;
                r1_next    = alu_rsp.y;
                sat_next   = sat_reg | alu_rsp.sat;
            end
            ST_D_MZH:
            begin
                alu_req.op = ALU_MZH;
                alu_req.a  = d1_reg;
                tmp_next   = alu_rsp.y;
            end
            ST_D_MZL:
            begin
                alu_req.op = ALU_MZL;
                alu_req.a  = d1_reg;
                alu_req.b  = tmp_reg;
                r2_next    = alu_rsp.y;
                sat_next   = sat_reg | alu_rsp.sat;
            end
            ST_D_MC2:
            begin
                alu_req.op = ALU_MULS;
                alu_req.a  = r2_reg;
                r2_next    = alu_rsp.y;
                sat_next   = sat_reg | alu_rsp.sat;
            end
            ST_D_ADD:
            begin
                alu_req.op = ALU_ADD;
                alu_req.a  = r1_reg;
                alu_req.b  = r2_reg;
                r1_next    = alu_rsp.y;
                sat_next   = sat_reg | alu_rsp.sat;
            end
            ST_D_MK:
            begin
                alu_req.op = ALU_MULS;
                alu_req.a  = d0_reg;
                alu_req.c  = k_reg;
                r2_next    = alu_rsp.y;
                sat_next   = sat_reg | alu_rsp.sat;
            end
            ST_D_SUB:
            begin
                alu_req.op = ALU_SUB;
                alu_req.a  = r1_reg;
                alu_req.b  = r2_reg;
                r1_next    = alu_rsp.y;
                sat_next   = sat_reg | alu_rsp.sat;
            end
            ST_D_DIV:
            begin
                div_req.start = 1'b1;
            end
            ST_D_WAIT:
            begin
                if (div_rsp.done)
                begin
                    a0_next = a1_reg;
                    a1_next = an_reg;
                    d0_next = d1_reg;
                    d1_next = div_rsp.y;
                    k_next  = kp1;
                end
            end
            // Post-loop combination
            ST_FIN:
            begin
                if (!op_reg[1])
                begin
                    r1_next = op_reg[0] ? d1_reg : a1_reg;
                end
                else
                begin
                    alu_req.op = ALU_ADD;
                    alu_req.a  = pa_reg;
                    alu_req.b  = a1_reg;
                    r1_next    = alu_rsp.y;
                    sat_next   = sat_reg | alu_rsp.sat;
                end
            end
            ST_G_ADD:
            begin
                alu_req.op = ALU_ADD;
                alu_req.a  = pda_reg;
                alu_req.b  = d1_reg;
                r2_next    = alu_rsp.y;
                sat_next   = sat_reg | alu_rsp.sat;
            end
            ST_P_DIV1, ST_P_DIV2:
            begin
                div_req.start = 1'b1;
                div_req.kind  = DIV_POINT;
            end
            ST_P_WAIT1, ST_P_WAIT2:
            begin
                if (div_rsp.done)
                begin
                    r1_next  = div_rsp.y;
                    sat_next = sat_reg | div_rsp.sat;
                end
            end
            ST_G_SUB:
            begin
                alu_req.op = ALU_SUB;
                alu_req.a  = r2_reg;
                alu_req.b  = r1_reg;
                r1_next    = alu_rsp.y;
                sat_next   = sat_reg | alu_rsp.sat;
            end
            // Clamp to Q23.32 and load the output register
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    bad_out_next   = bad_reg;
                    sat_out_next   = sat_reg | ov_hi | ov_lo;
                    if (ov_hi)
                    begin
                        value_next = OUT_MAX[55:0];
                    end
                    else if (ov_lo)
                    begin
                        value_next = OUT_MIN[55:0];
                    end
                    else
                    begin
                        value_next = r1_reg[55:0];
                    end
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg && out_stall;
            end
        endcase
    end

    assign in_stall   = (state_reg != ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign value      = value_reg;
    assign bad_degree = bad_out_reg;
    assign saturated  = sat_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        z_reg       <= z_next;
        n_reg       <= n_next;
        m_reg       <= m_next;
        k_reg       <= k_next;
        sat_reg     <= sat_next;
        bad_reg     <= bad_next;
        near_reg    <= near_next;
        a0_reg      <= a0_next;
        a1_reg      <= a1_next;
        d0_reg      <= d0_next;
        d1_reg      <= d1_next;
        pa_reg      <= pa_next;
        pda_reg     <= pda_next;
        an_reg      <= an_next;
        r1_reg      <= r1_next;
        r2_reg      <= r2_next;
        tmp_reg     <= tmp_next;
        value_reg   <= value_next;
        bad_out_reg <= bad_out_next;
        sat_out_reg <= sat_out_next;
    end

endmodule

`default_nettype wire

@@ sim/legendre_glj_poly_eval_core_tb.sv @@
`default_nettype none

module legendre_glj_poly_eval_core_tb;
    import lgp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Operation codes on the op port
    localparam logic [1:0] OP_LEG   = 2'd0;
    localparam logic [1:0] OP_LEGD  = 2'd1;
    localparam logic [1:0] OP_GLJ   = 2'd2;
    localparam logic [1:0] OP_GLJD  = 2'd3;

    localparam int  DEG_CAP     = 63;
    localparam int  N_RANDOM    = 800;
    localparam int  CYCLE_LIMIT = 4000000;
    localparam int  HOLD_CYCLES = 4000;
    localparam longint Q32      = 64'sh1_0000_0000;
    localparam longint ZM1      = -64'sd1073741824;

    typedef struct {
        logic [1:0]  op;
        logic [31:0] point;
        logic [5:0]  degree;
        bit          typed;
        logic [55:0] value;
        logic        bad;
        logic        sat;
    } item_t;

    typedef struct {
        logic [55:0] value;
        logic        bad;
        logic        sat;
    } result_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         op;
    logic signed [31:0] point;
    logic [5:0]         degree;
    logic               out_valid;
    logic               out_stall;
    logic signed [55:0] value;
    logic               bad_degree;
    logic               saturated;

    legendre_glj_poly_eval_core u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .op         (op),
        .point      (point),
        .degree     (degree),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .value      (value),
        .bad_degree (bad_degree),
        .saturated  (saturated)
    );

    // Clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    item_t   stim_q[$];
    result_t pending_q[$];
    int      sent_cnt;
    int      recv_cnt;
    int      err_cnt;
    int      sat_cnt;
    int      near_cnt;
    bit      fx_sat;

    // ---------------- fixed-point predictor ----------------
    function automatic logic [63:0] fx_mag(longint a);
        return (a < 0) ? (64'd0 - a) : a;
    endfunction

    function automatic longint fx_from_mag(logic [63:0] m, bit neg);
        if (m > LIM)
        begin
            m = LIM;
            fx_sat = 1'b1;
        end
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint fx_add(longint a, longint b);
        longint s;
        s = a + b;
        if (s > LIM_S)
        begin
            s = LIM_S;
            fx_sat = 1'b1;
        end
        if (s < NLIM_S)
        begin
            s = NLIM_S;
            fx_sat = 1'b1;
        end
        return s;
    endfunction

    function automatic longint fx_mul_point(longint a, longint zr);
        logic [63:0] am, zm, hi, lo, t, lp;
        bit neg;
        am  = fx_mag(a);
        zm  = fx_mag(zr);
        hi  = am >> 32;
        lo  = am & 64'hFFFF_FFFF;
        t   = hi * zm;
        lp  = lo * zm + (64'd1 << 29);
        neg = (a < 0) != (zr < 0);
        if (t > (LIM >> 2))
        begin
            fx_sat = 1'b1;
            return neg ? NLIM_S : LIM_S;
        end
        return fx_from_mag((t << 2) + (lp >> 30), neg);
    endfunction

    function automatic longint fx_mul_int(longint a, logic [63:0] c);
        logic [63:0] am;
        am = fx_mag(a);
        if (am > LIM / c)
        begin
            fx_sat = 1'b1;
            return (a < 0) ? NLIM_S : LIM_S;
        end
        return fx_from_mag(am * c, a < 0);
    endfunction

    function automatic longint fx_div_int(longint a, logic [63:0] d);
        logic [63:0] q;
        q = (fx_mag(a) + d / 2) / d;
        return (a < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint fx_div_point(longint num, longint d);
        logic [63:0] m, dm, hi, lo, rem, q, b;
        bit ovf, neg;
        m   = fx_mag(num);
        dm  = fx_mag(d);
        hi  = m >> 34;
        lo  = m << 30;
        rem = 0;
        q   = 0;
        ovf = 1'b0;
        neg = (num < 0) != (d < 0);
        for (int i = 127; i >= 0; i--)
        begin
            b   = (i >= 64) ? ((hi >> (i - 64)) & 64'd1) : ((lo >> i) & 64'd1);
            rem = (rem << 1) | b;
            if ((q >> 62) != 0)
                ovf = 1'b1;
            q = q << 1;
            if (rem >= dm)
            begin
                rem = rem - dm;
                q   = q | 64'd1;
            end
        end
        if (!ovf && rem >= dm - rem)
            q = q + 1;
        if (ovf)
        begin
            fx_sat = 1'b1;
            return neg ? NLIM_S : LIM_S;
        end
        return fx_from_mag(q, neg);
    endfunction

    // three-term recurrence for P_m and P'_m, m >= 1
    task automatic legendre_pair(input longint zr, input int m,
                                 output longint p, output longint pd);
        longint a0, a1, d0, d1, t, a2, d2;
        logic [63:0] c;
        a0 = Q32;
        a1 = zr * 4;
        d0 = 0;
        d1 = Q32;
        for (int k = 1; k < m; k++)
        begin
            c  = 2 * k + 1;
            t  = fx_add(fx_mul_int(fx_mul_point(a1, zr), c), -fx_mul_int(a0, k));
            a2 = fx_div_int(t, k + 1);
            t  = fx_add(fx_mul_int(a1, c), fx_mul_int(fx_mul_point(d1, zr), c));
            t  = fx_add(t, -fx_mul_int(d0, k));
            d2 = fx_div_int(t, k + 1);
            a0 = a1;
            a1 = a2;
            d0 = d1;
            d1 = d2;
        end
        p  = a1;
        pd = d1;
    endtask

    task automatic predict_poly(input logic [1:0] f_op, input logic [31:0] f_pt,
                                input logic [5:0] f_deg, output result_t r);
        longint zr, onepz, v, pa, pda, pb, pdb, bsum, asum, t;
        int n;
        bit near;
        zr     = longint'(signed'(f_pt));
        n      = f_deg;
        onepz  = zr + 64'sd1073741824;
        near   = (onepz >= -1) && (onepz <= 1);
        fx_sat = 1'b0;
        v      = 0;
        if (n == 0)
        begin
            r.value = '0;
            r.bad   = 1'b1;
            r.sat   = 1'b0;
            return;
        end
        if (n > DEG_CAP)
            n = DEG_CAP;
        if (f_op == OP_LEG || f_op == OP_LEGD)
        begin
            legendre_pair(zr, n, pa, pda);
            v = (f_op == OP_LEG) ? pa : pda;
        end
        else if (near)
        begin
            if (f_op == OP_GLJ)
            begin
                v = longint'(n + 1) * Q32;
                if (n % 2 == 1)
                    v = -v;
            end
            else
            begin
                legendre_pair(ZM1, n, pa, pda);
                legendre_pair(ZM1, n + 1, pb, pdb);
                v = fx_add(pa, pb);
            end
        end
        else
        begin
            legendre_pair(zr, n, pa, pda);
            legendre_pair(zr, n + 1, pb, pdb);
            bsum = fx_add(pa, pb);
            if (f_op == OP_GLJ)
                v = fx_div_point(bsum, onepz);
            else
            begin
                asum = fx_add(pda, pdb);
                t    = fx_div_point(bsum, onepz);
                v    = fx_div_point(fx_add(asum, -t), onepz);
            end
        end
        if (v > OUT_MAX)
        begin
            v      = OUT_MAX;
            fx_sat = 1'b1;
        end
        if (v < OUT_MIN)
        begin
            v      = OUT_MIN;
            fx_sat = 1'b1;
        end
        r.value = v[55:0];
        r.bad   = 1'b0;
        r.sat   = fx_sat;
    endtask

    // ---------------- stimulus build ----------------
    function automatic item_t mk(logic [1:0] o, logic [31:0] p, logic [5:0] d);
        item_t it;
        it.op     = o;
        it.point  = p;
        it.degree = d;
        it.typed  = 1'b0;
        it.value  = '0;
        it.bad    = 1'b0;
        it.sat    = 1'b0;
        return it;
    endfunction

    function automatic item_t mk_typed(logic [1:0] o, logic [31:0] p, logic [5:0] d,
                                       logic [55:0] v, logic b);
        item_t it;
        it       = mk(o, p, d);
        it.typed = 1'b1;
        it.value = v;
        it.bad   = b;
        return it;
    endfunction

    task automatic build_stimulus();
        item_t directed[$];
        logic [31:0] pt;
        int sel;
        // zero degree on every op
        directed.push_back(mk_typed(OP_LEG,  32'h1234_5678, 6'd0, 56'd0, 1'b1));
        directed.push_back(mk_typed(OP_LEGD, 32'h8000_0000, 6'd0, 56'd0, 1'b1));
        directed.push_back(mk_typed(OP_GLJ,  32'hC000_0000, 6'd0, 56'd0, 1'b1));
        directed.push_back(mk_typed(OP_GLJD, 32'h7FFF_FFFF, 6'd0, 56'd0, 1'b1));
        // degree one at the origin: P_1 = z = 0, P'_1 = 1
        directed.push_back(mk_typed(OP_LEG,  32'h0000_0000, 6'd1, 56'd0, 1'b0));
        directed.push_back(mk_typed(OP_LEGD, 32'h0000_0000, 6'd1, 56'h1_0000_0000, 1'b0));
        // GLJ value at exactly -1 and its neighbors: (n+1)(-1)^n
        directed.push_back(mk_typed(OP_GLJ, 32'hC000_0000, 6'd1, -56'sh2_0000_0000, 1'b0));
        directed.push_back(mk_typed(OP_GLJ, 32'hC000_0001, 6'd2, 56'h3_0000_0000, 1'b0));
        directed.push_back(mk_typed(OP_GLJ, 32'hBFFF_FFFF, 6'd63, -56'sh40_0000_0000, 1'b0));
        // GLJ derivative near -1, and GLJ value and derivative just outside the window
        directed.push_back(mk(OP_GLJD, 32'hC000_0000, 6'd3));
        directed.push_back(mk(OP_GLJD, 32'hC000_0001, 6'd1));
        directed.push_back(mk(OP_GLJ,  32'hC000_0002, 6'd2));
        directed.push_back(mk(OP_GLJD, 32'hBFFF_FFFE, 6'd2));
        // point extremes, degree extremes, clamping
        directed.push_back(mk(OP_LEG,  32'h7FFF_FFFF, 6'd63));
        directed.push_back(mk(OP_LEGD, 32'h8000_0000, 6'd63));
        directed.push_back(mk(OP_GLJ,  32'h7FFF_FFFF, 6'd63));
        directed.push_back(mk(OP_GLJD, 32'h8000_0000, 6'd63));
        directed.push_back(mk(OP_LEG,  32'h4000_0000, 6'd63));
        directed.push_back(mk(OP_LEGD, 32'h4000_0000, 6'd63));
        directed.push_back(mk(OP_GLJ,  32'h4000_0000, 6'd5));
        directed.push_back(mk(OP_GLJD, 32'h2000_0000, 6'd4));
        directed.push_back(mk(OP_LEG,  32'hFFFF_FFFF, 6'd2));
        foreach (directed[i])
            stim_q.push_back(directed[i]);

        // random part: mostly small degrees, a few large ones
        for (int i = 0; i < N_RANDOM; i++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 30)
                pt = $urandom();
            else if (sel < 70)
                pt = 32'(int'($urandom_range(0, 32'h8000_0000)) - 32'sh4000_0000);
            else if (sel < 85)
                pt = 32'hC000_0000 + 32'($urandom_range(0, 6)) - 32'd3;
            else
                pt = 32'hC000_0000 + 32'($urandom_range(0, 2000)) - 32'd1000;
            sel = $urandom_range(0, 99);
            if (sel < 5)
                stim_q.push_back(mk(2'($urandom()), pt, 6'd0));
            else if (sel < 90)
                stim_q.push_back(mk(2'($urandom()), pt, 6'($urandom_range(1, 10))));
            else
                stim_q.push_back(mk(2'($urandom()), pt, 6'($urandom())));
        end
    endtask

    // ---------------- reset and sender ----------------
    initial
    begin
        item_t   it;
        result_t r;
        int      burst_left;
        int      gap_left;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        op         = '0;
        point      = '0;
        degree     = '0;
        sent_cnt   = 0;
        burst_left = 0;
        gap_left   = 0;
        build_stimulus();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (in_valid && !in_stall)
            begin
                it = stim_q[sent_cnt];
                predict_poly(it.op, it.point, it.degree, r);
                if (it.typed)
                begin
                    r.value = it.value;
                    r.bad   = it.bad;
                    r.sat   = it.sat;
                end
                if (r.sat)
                    sat_cnt++;
                if (it.op[1] && (it.point >= 32'hBFFF_FFFF) && (it.point <= 32'hC000_0001))
                    near_cnt++;
                pending_q.push_back(r);
                sent_cnt++;
            end
            // hold an offered item until it transfers
            if (!(in_valid && in_stall))
            begin
                if (sent_cnt >= stim_q.size())
                    in_valid <= 1'b0;
                else if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else
                begin
                    if (burst_left == 0)
                        burst_left = $urandom_range(1, 12);
                    burst_left--;
                    if (burst_left == 0)
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
                    in_valid <= 1'b1;
                    op       <= stim_q[sent_cnt].op;
                    point    <= stim_q[sent_cnt].point;
                    degree   <= stim_q[sent_cnt].degree;
                end
            end
        end
    end

    // ---------------- receiver stall pattern ----------------
    initial
    begin
        int  mode;
        int  hold_cnt;
        bit  held;
        out_stall = 1'b0;
        held      = 1'b0;
        forever
        begin
            mode = $urandom_range(0, 3);
            repeat ($urandom_range(16, 128))
            begin
                @(posedge clk);
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 1) == 0);
                    2: out_stall <= ($urandom_range(0, 7) == 0);
                    default: out_stall <= ($urandom_range(0, 7) != 0);
                endcase
            end
            // one long hold-off while the sender keeps offering
            if (!held && sent_cnt > 100)
            begin
                held = 1'b1;
                hold_cnt = 0;
                while (hold_cnt < HOLD_CYCLES)
                begin
                    @(posedge clk);
                    out_stall <= 1'b1;
                    hold_cnt++;
                end
            end
        end
    end

    // ---------------- result checker ----------------
    initial
    begin
        result_t e;
        recv_cnt = 0;
        err_cnt  = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                recv_cnt++;
                if (pending_q.size() == 0)
                begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("result transfer with nothing pending: value=%h", value);
                end
                else
                begin
                    e = pending_q.pop_front();
                    if (value !== e.value || bad_degree !== e.bad || saturated !== e.sat)
                    begin
                        err_cnt++;
                        if (err_cnt <= 10)
                            $display("mismatch #%0d: value %h/%h bad %b/%b sat %b/%b (exp/got)",
                                     recv_cnt, e.value, value, e.bad, bad_degree,
                                     e.sat, saturated);
                    end
                end
            end
        end
    end

    // ---------------- end of run and timeout ----------------
    initial
    begin
        int cyc;
        cyc = 0;
        while (cyc < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cyc++;
            if (stim_q.size() > 0 && sent_cnt == stim_q.size() && pending_q.size() == 0)
                break;
        end
        if (cyc >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d transfers in, %0d out",
                     cyc, sent_cnt, recv_cnt);
            $display("legendre_glj_poly_eval_core_tb failed");
        end
        else
        begin
            repeat (300) @(posedge clk);
            $display("covered %0d items over all four ops, %0d near -1, %0d clamped",
                     sent_cnt, near_cnt, sat_cnt);
            $display("%0d results checked, %0d mismatches", recv_cnt, err_cnt);
            if (err_cnt == 0 && pending_q.size() == 0)
                $display("legendre_glj_poly_eval_core_tb passed");
            else
                $display("legendre_glj_poly_eval_core_tb failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ filelist.f @@
hw/rtl/lgp_pkg.sv
hw/rtl/lgp_alu.sv
hw/rtl/lgp_div.sv
hw/rtl/legendre_glj_poly_eval_core.sv
sim/legendre_glj_poly_eval_core_tb.sv
